FILE: sv/assert_macros.svh
// Assertion macros for the squelch and signal meter checkers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, ignored while reset is high
`define RSM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising edge, reset included
`define RSM_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/rsm_pkg.sv
`default_nettype none

package rsm_pkg;

   localparam int unsigned RssiWidth   = 8;
   localparam int unsigned SnrWidth    = 6;
   localparam int unsigned MarginWidth = 4;
   localparam int unsigned AlphaWidth  = 8;
   localparam int unsigned LevelWidth  = 16;
   localparam int unsigned MeterWidth  = 4;
   localparam int unsigned MeterSteps  = 10;
   localparam int unsigned CsrAddrWidth = 3;
   localparam int unsigned CsrDataWidth = 8;
   localparam int unsigned ReqDataWidth = 16;
   localparam int unsigned RspDataWidth = 24;

   typedef enum logic [CsrAddrWidth-1:0] {
      CSR_SQUELCH_THRESHOLD = 3'd0,
      CSR_HYSTERESIS_MARGIN = 3'd1,
      CSR_SNR_MINIMUM       = 3'd2,
      CSR_ALPHA_IDLE        = 3'd3,
      CSR_ALPHA_ACTIVE      = 3'd4
   } csr_addr_type;

   typedef struct packed {
      logic [RssiWidth-1:0]   squelch_threshold;
      logic [MarginWidth-1:0] hysteresis_margin;
      logic [SnrWidth-1:0]    snr_minimum;
      logic [AlphaWidth-1:0]  alpha_idle;
      logic [AlphaWidth-1:0]  alpha_active;
   } csr_type;

   localparam csr_type CsrReset = '{
      squelch_threshold: 8'd80,
      hysteresis_margin: 4'd3,
      snr_minimum:       6'd2,
      alpha_idle:        8'd51,
      alpha_active:      8'd154
   };

   typedef logic [RssiWidth-1:0] meter_table_type [MeterSteps];

   localparam meter_table_type MeterTable = '{
      8'd64, 8'd70, 8'd76, 8'd82, 8'd89, 8'd97, 8'd104, 8'd112, 8'd118, 8'd125
   };

endpackage

`default_nettype wire

FILE: sv/rsm_smooth.sv
`default_nettype none

module rsm_smooth (
   input  wire logic [rsm_pkg::AlphaWidth-1:0] alpha,
   input  wire logic [rsm_pkg::RssiWidth-1:0]  rssi,
   input  wire logic [rsm_pkg::LevelWidth-1:0] prev,
   output logic      [rsm_pkg::LevelWidth-1:0] level
);
   import rsm_pkg::*;

   logic signed [16:0] diff;
   logic signed [25:0] prod;
   logic signed [25:0] rounded;
   logic signed [17:0] delta;
   logic signed [17:0] sum;

   // prev + round(alpha * (R - prev) / 256), one multiply
   always_comb begin
      diff    = $signed({1'b0, rssi, 8'b0}) - $signed({1'b0, prev});
      prod    = $signed({1'b0, alpha}) * diff;
      rounded = prod + 26'sd128;
      delta   = rounded[25:8];
      sum     = $signed({2'b00, prev}) + delta;
      priority if (sum[17]) begin
         level = '0;
      end else if (sum[16]) begin
         level = '1;
      end else begin
         level = sum[15:0];
      end
   end

endmodule

`default_nettype wire

FILE: sv/rsm_squelch.sv
`default_nettype none

module rsm_squelch (
   input  wire rsm_pkg::csr_type                 csr,
   input  wire logic                             rx_now,
   input  wire logic [rsm_pkg::LevelWidth-1:0]   level,
   input  wire logic [rsm_pkg::SnrWidth-1:0]     snr,
   input  wire logic                             transmitting,
   output logic                                  rx_next
);
   import rsm_pkg::*;

   logic       [8:0]  open_level;
   logic signed [9:0] close_level;
   logic              above_open;
   logic              below_close;
   logic              snr_ok;

   always_comb begin
      open_level  = {1'b0, csr.squelch_threshold} + {5'b0, csr.hysteresis_margin};
      close_level = $signed({2'b00, csr.squelch_threshold})
                  - $signed({6'b0, csr.hysteresis_margin});
      above_open  = {1'b0, level} > {open_level, 8'b0};
      below_close = $signed({2'b00, level}) < $signed({close_level, 8'b0});
      snr_ok      = snr >= csr.snr_minimum;
      if (rx_now) begin
         rx_next = !(below_close || !snr_ok);
      end else begin
         rx_next = above_open && snr_ok && !transmitting;
      end
   end

endmodule

`default_nettype wire

FILE: sv/rsm_meter.sv
`default_nettype none

module rsm_meter (
   input  wire logic [rsm_pkg::RssiWidth-1:0]  rssi,
   output logic      [rsm_pkg::MeterWidth-1:0] meter
);
   import rsm_pkg::*;

   logic [MeterSteps-1:0] above;

   always_comb begin
      for (int i = 0; i < MeterSteps; i++) begin
         above[i] = rssi > MeterTable[i];
      end
      meter = MeterWidth'($countones(above));
   end

endmodule

`default_nettype wire

FILE: sv/rssi_squelch_and_signal_meter_top.sv
// An accepted request is registered in the input stage, then in the output stage.
// Throughput: one transaction per cycle unless rsp_tready stalls the output; the
// smoothed level and squelch flag close their loop within the single compute stage.
// Reset (synchronous, active high): empties both stages, clears the smoothed
// level and the squelch flag, and loads the default register values.
`default_nettype none

module rssi_squelch_and_signal_meter_top (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // rssi_sample [7:0], snr_sample [13:8], transmitting [14], zero [15]
   input  wire logic [rsm_pkg::ReqDataWidth-1:0]   req_tdata,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // signal_present [0], meter_level [4:1], smoothed_level [20:5], zero [23:21]
   output logic      [rsm_pkg::RspDataWidth-1:0]   rsp_tdata,
   input  wire logic                               csr_we,
   input  wire logic [rsm_pkg::CsrAddrWidth-1:0]   csr_addr,
   input  wire logic [rsm_pkg::CsrDataWidth-1:0]   csr_wdata
);
   import rsm_pkg::*;

   csr_type                csr_ff, csr_in;
   logic                   in_valid_ff, in_valid_in;
   logic [RssiWidth-1:0]   in_rssi_ff, in_rssi_in;
   logic [SnrWidth-1:0]    in_snr_ff, in_snr_in;
   logic                   in_tx_ff, in_tx_in;
   logic                   out_valid_ff, out_valid_in;
   logic [RspDataWidth-1:0] out_data_ff, out_data_in;
   logic [LevelWidth-1:0]  level_ff, level_in;
   logic                   rx_ff, rx_in;

   logic                   out_free;
   logic                   advance;
   logic                   req_take;
   logic [AlphaWidth-1:0]  alpha;
   logic [LevelWidth-1:0]  level_next;
   logic                   rx_next;
   logic [MeterWidth-1:0]  meter;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign req_take   = req_tvalid && req_tready;
   assign alpha      = rx_ff ? csr_ff.alpha_active : csr_ff.alpha_idle;

   rsm_smooth u_smooth (
      .alpha (alpha),
      .rssi  (in_rssi_ff),
      .prev  (level_ff),
      .level (level_next)
   );

   rsm_squelch u_squelch (
      .csr          (csr_ff),
      .rx_now       (rx_ff),
      .level        (level_next),
      .snr          (in_snr_ff),
      .transmitting (in_tx_ff),
      .rx_next      (rx_next)
   );

   rsm_meter u_meter (
      .rssi  (in_rssi_ff),
      .meter (meter)
   );

   always_comb begin
      csr_in = csr_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_SQUELCH_THRESHOLD: csr_in.squelch_threshold = csr_wdata;
            CSR_HYSTERESIS_MARGIN: csr_in.hysteresis_margin = csr_wdata[MarginWidth-1:0];
            CSR_SNR_MINIMUM:       csr_in.snr_minimum       = csr_wdata[SnrWidth-1:0];
            CSR_ALPHA_IDLE:        csr_in.alpha_idle        = csr_wdata;
            CSR_ALPHA_ACTIVE:      csr_in.alpha_active      = csr_wdata;
            default:               csr_in = csr_ff;
         endcase
      end
   end

   always_comb begin
      in_valid_in = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      in_rssi_in  = req_take ? req_tdata[7:0]  : in_rssi_ff;
      in_snr_in   = req_take ? req_tdata[13:8] : in_snr_ff;
      in_tx_in    = req_take ? req_tdata[14]   : in_tx_ff;

      out_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);
      out_data_in  = advance ? {3'b000, level_next, meter, rx_next} : out_data_ff;
      level_in     = advance ? level_next : level_ff;
      rx_in        = advance ? rx_next : rx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff       <= CsrReset;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         level_ff     <= '0;
         rx_ff        <= 1'b0;
      end else begin
         csr_ff       <= csr_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         level_ff     <= level_in;
         rx_ff        <= rx_in;
      end
   end

   always_ff @(posedge clock) begin
      in_rssi_ff  <= in_rssi_in;
      in_snr_ff   <= in_snr_in;
      in_tx_ff    <= in_tx_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

`default_nettype wire

FILE: sv/rsm_checker.sv
`default_nettype none

`include "assert_macros.svh"

module rsm_checker (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   input  wire logic [rsm_pkg::RspDataWidth-1:0]  rsp_tdata
);
   import rsm_pkg::*;

   logic stalled;
   logic fields_ok;

   assign stalled   = rsp_tvalid && !rsp_tready;
   assign fields_ok = (rsp_tdata[4:1] <= 4'd10) && (rsp_tdata[23:21] == 3'b000);

   `RSM_ASSERT(rsp_hold_a, clock, reset, stalled |=> rsp_tvalid, "response dropped")
   `RSM_ASSERT(rsp_stable_a, clock, reset, stalled |=> $stable(rsp_tdata), "held response changed")
   `RSM_ASSERT(rsp_range_a, clock, reset, rsp_tvalid |-> fields_ok, "meter or padding bad")
   `RSM_ASSERT_ALWAYS(rsp_reset_a, clock, (!reset && $past(reset)) |-> !rsp_tvalid, "valid after reset")

endmodule

bind rssi_squelch_and_signal_meter_top rsm_checker u_rsm_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

FILE: verif/tb_rssi_squelch_and_signal_meter_top.sv
`timescale 1ns / 100ps

module tb_rssi_squelch_and_signal_meter_top;
   import rsm_pkg::*;

   localparam int unsigned DrainCycles   = 8;
   localparam int unsigned CycleLimit    = 200000;
   localparam int unsigned RandomPhases  = 10;
   localparam int unsigned PollsPerPhase = 100;
   localparam int unsigned MaxGap        = 10;
   localparam int unsigned FracBits      = 8;
   localparam int unsigned QOne          = 256;
   localparam int unsigned QHalf         = 128;
   localparam int unsigned LevelMax      = 65535;
   localparam int unsigned RssiMax       = 255;
   localparam int unsigned SnrMax        = 63;
   localparam int unsigned CsrCount      = 5;
   localparam logic [CsrAddrWidth-1:0] CsrFirstUnmapped = 3'd5;
   localparam logic [CsrAddrWidth-1:0] CsrLastUnmapped  = 3'd7;
   localparam int unsigned NumRows       = 27;

   typedef enum logic {ROW_POLL, ROW_CSR} row_kind_type;

   typedef struct packed {
      logic                  present;
      logic [MeterWidth-1:0] meter;
      logic [LevelWidth-1:0] level;
   } reading_type;

   typedef struct packed {
      row_kind_type            kind;
      logic [CsrAddrWidth-1:0] addr;
      logic [CsrDataWidth-1:0] wdata;
      logic [RssiWidth-1:0]    rssi;
      logic [SnrWidth-1:0]     snr;
      logic                    tx;
      logic                    typed;
      reading_type             want;
   } row_type;

   localparam row_type DirectedRows [NumRows] = '{
      '{ROW_POLL, '0, 8'h00, 8'd0, 6'd0, 1'b0, 1'b1, '{1'b0, 4'd0, 16'd0}},
      '{ROW_CSR, CSR_ALPHA_IDLE, 8'd0, 8'd0, 6'd0, 1'b0, 1'b0, '0},
      '{ROW_POLL, '0, 8'h00, 8'd64, 6'd63, 1'b0, 1'b1, '{1'b0, 4'd0, 16'd0}},
      '{ROW_POLL, '0, 8'h00, 8'd65, 6'd63, 1'b0, 1'b1, '{1'b0, 4'd1, 16'd0}},
      '{ROW_POLL, '0, 8'h00, 8'd125, 6'd63, 1'b0, 1'b1, '{1'b0, 4'd9, 16'd0}},
      '{ROW_POLL, '0, 8'h00, 8'd126, 6'd63, 1'b0, 1'b1, '{1'b0, 4'd10, 16'd0}},
      '{ROW_POLL, '0, 8'h00, 8'd255, 6'd63, 1'b0, 1'b1, '{1'b0, 4'd10, 16'd0}},
      '{ROW_CSR, CSR_ALPHA_IDLE, 8'd51, 8'd0, 6'd0, 1'b0, 1'b0, '0},
      '{ROW_POLL, '0, 8'h00, 8'd255, 6'd63, 1'b1, 1'b0, '0},
      '{ROW_POLL, '0, 8'h00, 8'd255, 6'd63, 1'b1, 1'b0, '0},
      '{ROW_POLL, '0, 8'h00, 8'd255, 6'd63, 1'b1, 1'b0, '0},
      '{ROW_POLL, '0, 8'h00, 8'd255, 6'd63, 1'b0, 1'b0, '0},
      '{ROW_POLL, '0, 8'h00, 8'd255, 6'd1, 1'b0, 1'b0, '0},
      '{ROW_POLL, '0, 8'h00, 8'd255, 6'd2, 1'b0, 1'b0, '0},
      '{ROW_POLL, '0, 8'h00, 8'd255, 6'd63, 1'b1, 1'b0, '0},
      '{ROW_POLL, '0, 8'h00, 8'd0, 6'd63, 1'b0, 1'b0, '0},
      '{ROW_POLL, '0, 8'h00, 8'd0, 6'd63, 1'b0, 1'b0, '0},
      '{ROW_POLL, '0, 8'h00, 8'd0, 6'd63, 1'b0, 1'b0, '0},
      '{ROW_CSR, CSR_SQUELCH_THRESHOLD, 8'd5, 8'd0, 6'd0, 1'b0, 1'b0, '0},
      '{ROW_CSR, CSR_HYSTERESIS_MARGIN, 8'hFF, 8'd0, 6'd0, 1'b0, 1'b0, '0},
      '{ROW_CSR, CSR_SNR_MINIMUM, 8'hC0, 8'd0, 6'd0, 1'b0, 1'b0, '0},
      '{ROW_CSR, CsrLastUnmapped, 8'hAA, 8'd0, 6'd0, 1'b0, 1'b0, '0},
      '{ROW_POLL, '0, 8'h00, 8'd255, 6'd0, 1'b0, 1'b0, '0},
      '{ROW_POLL, '0, 8'h00, 8'd255, 6'd0, 1'b0, 1'b0, '0},
      '{ROW_POLL, '0, 8'h00, 8'd0, 6'd0, 1'b0, 1'b0, '0},
      '{ROW_POLL, '0, 8'h00, 8'd0, 6'd0, 1'b0, 1'b0, '0},
      '{ROW_POLL, '0, 8'h00, 8'd0, 6'd0, 1'b0, 1'b0, '0}
   };

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [ReqDataWidth-1:0]  req_tdata  = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RspDataWidth-1:0]  rsp_tdata;
   logic                     csr_we     = 1'b0;
   logic [CsrAddrWidth-1:0]  csr_addr   = '0;
   logic [CsrDataWidth-1:0]  csr_wdata  = '0;

   logic [RssiWidth-1:0]     cfg_threshold    = CsrReset.squelch_threshold;
   logic [MarginWidth-1:0]   cfg_margin       = CsrReset.hysteresis_margin;
   logic [SnrWidth-1:0]      cfg_snr_min      = CsrReset.snr_minimum;
   logic [AlphaWidth-1:0]    cfg_alpha_idle   = CsrReset.alpha_idle;
   logic [AlphaWidth-1:0]    cfg_alpha_active = CsrReset.alpha_active;
   logic [LevelWidth-1:0]    smooth_q88       = '0;
   logic                     squelch_open     = 1'b0;

   reading_type              pending_readings [$];
   int unsigned              mismatches     = 0;
   int unsigned              polls_sent     = 0;
   int unsigned              directed_polls = 0;
   int unsigned              readings_seen  = 0;
   int unsigned              opens          = 0;
   int unsigned              closes         = 0;
   int unsigned              settings_used  = 1;
   int unsigned              cycles         = 0;
   bit                       calm           = 1'b0;

   rssi_squelch_and_signal_meter_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CycleLimit) begin
         $display("%0t: run did not complete within %0d cycles", $time, CycleLimit);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic int unsigned idle_draw();
      return calm ? 0 : $urandom_range(0, MaxGap);
   endfunction

   function automatic void apply_csr(input logic [CsrAddrWidth-1:0] addr,
                                     input logic [CsrDataWidth-1:0] data);
      case (addr)
         CSR_SQUELCH_THRESHOLD: cfg_threshold    = data[RssiWidth-1:0];
         CSR_HYSTERESIS_MARGIN: cfg_margin       = data[MarginWidth-1:0];
         CSR_SNR_MINIMUM:       cfg_snr_min      = data[SnrWidth-1:0];
         CSR_ALPHA_IDLE:        cfg_alpha_idle   = data[AlphaWidth-1:0];
         CSR_ALPHA_ACTIVE:      cfg_alpha_active = data[AlphaWidth-1:0];
         default: ;
      endcase
   endfunction

   function automatic reading_type squelch_poll(input logic [RssiWidth-1:0] rssi,
                                                input logic [SnrWidth-1:0]  snr,
                                                input logic                 tx);
      int unsigned alpha;
      int unsigned acc;
      int unsigned open_level;
      int          close_level;
      int          i;
      reading_type r;
      alpha = squelch_open ? 32'(cfg_alpha_active) : 32'(cfg_alpha_idle);
      acc = (alpha * (32'(rssi) << FracBits) + (QOne - alpha) * 32'(smooth_q88) + QHalf)
            >> FracBits;
      if (acc > LevelMax) begin
         acc = LevelMax;
      end
      smooth_q88 = acc[LevelWidth-1:0];
      if (!squelch_open) begin
         open_level = (32'(cfg_threshold) + 32'(cfg_margin)) << FracBits;
         if (acc > open_level && snr >= cfg_snr_min && !tx) begin
            squelch_open = 1'b1;
            opens++;
         end
      end else begin
         // closing level is signed: a margin above the threshold never closes on level
         close_level = (int'(cfg_threshold) - int'(cfg_margin)) <<< FracBits;
         if (int'(acc) < close_level || snr < cfg_snr_min) begin
            squelch_open = 1'b0;
            closes++;
         end
      end
      r.meter = '0;
      for (i = 0; i < MeterSteps; i++) begin
         if (rssi > MeterTable[i]) begin
            r.meter = r.meter + 1'b1;
         end
      end
      r.present = squelch_open;
      r.level   = smooth_q88;
      return r;
   endfunction

   // drop valid and wait for every response to come back
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_readings.size() != 0) begin
         @(posedge clock);
      end
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CsrAddrWidth-1:0] addr,
                            input logic [CsrDataWidth-1:0] data);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(posedge clock);
      apply_csr(addr, data);
   endtask

   task automatic send_poll(input logic [RssiWidth-1:0] rssi,
                            input logic [SnrWidth-1:0]  snr,
                            input logic                 tx,
                            input logic                 typed,
                            input reading_type          want);
      int unsigned gap;
      reading_type predicted;
      gap = idle_draw();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, tx, snr, rssi};
      do @(posedge clock); while (!req_tready);
      predicted = squelch_poll(rssi, snr, tx);
      pending_readings.push_back(typed ? want : predicted);
      polls_sent++;
   endtask

   task automatic run_phase(input int unsigned phase);
      int unsigned r;
      int unsigned sel;
      int unsigned n;
      int unsigned run_left;
      int unsigned mode;
      int          level;
      logic [CsrDataWidth-1:0] value;
      logic [SnrWidth-1:0]     snr;
      settle();
      for (r = 0; r < CsrCount; r++) begin
         sel = (phase + r) % 3;
         value = (sel == 0) ? '0 : (sel == 1) ? '1 : CsrDataWidth'($urandom_range(0, RssiMax));
         csr_write(CsrAddrWidth'(r), value);
      end
      if ($urandom_range(0, 3) == 0) begin
         csr_write(CsrAddrWidth'($urandom_range(CsrFirstUnmapped, CsrLastUnmapped)),
                   CsrDataWidth'($urandom_range(0, RssiMax)));
      end
      csr_we <= 1'b0;
      settings_used++;
      run_left = 0;
      mode = 0;
      for (n = 0; n < PollsPerPhase; n++) begin
         if (run_left == 0) begin
            run_left = $urandom_range(5, 30);
            mode     = $urandom_range(0, 3);
            calm     = ($urandom_range(0, 3) == 0);
         end
         run_left--;
         case (mode)
            0: level = int'(cfg_threshold) + int'(cfg_margin) + int'($urandom_range(0, 60));
            1: level = int'(cfg_threshold) - int'(cfg_margin) - int'($urandom_range(0, 60));
            2: level = int'(cfg_threshold) - int'(cfg_margin) - 8
                       + int'($urandom_range(0, 2 * cfg_margin + 16));
            default: level = int'($urandom_range(0, RssiMax));
         endcase
         if (level < 0) begin
            level = 0;
         end
         if (level > int'(RssiMax)) begin
            level = RssiMax;
         end
         snr = ($urandom_range(0, 99) < 85) ? SnrWidth'($urandom_range(cfg_snr_min, SnrMax))
                                            : SnrWidth'($urandom_range(0, SnrMax));
         send_poll(RssiWidth'(level), snr, ($urandom_range(0, 9) == 0), 1'b0, '0);
      end
   endtask

   initial begin
      reading_type want;
      reading_type got;
      int unsigned stall;
      while (reset) @(posedge clock);
      forever begin
         stall = idle_draw();
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         got.present = rsp_tdata[0];
         got.meter   = rsp_tdata[4:1];
         got.level   = rsp_tdata[20:5];
         readings_seen++;
         if (pending_readings.size() == 0) begin
            $display("%0t: unexpected transaction, expected none actual %h", $time, rsp_tdata);
            mismatches++;
         end else begin
            want = pending_readings.pop_front();
            if (got.present !== want.present) begin
               $display("%0t: signal_present expected %0d actual %0d",
                        $time, want.present, got.present);
               mismatches++;
            end
            if (got.meter !== want.meter) begin
               $display("%0t: meter_level expected %0d actual %0d",
                        $time, want.meter, got.meter);
               mismatches++;
            end
            if (got.level !== want.level) begin
               $display("%0t: smoothed_level expected %0d actual %0d",
                        $time, want.level, got.level);
               mismatches++;
            end
         end
      end
   end

   initial begin
      int unsigned k;
      int unsigned p;
      bit          writing;
      writing = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      for (k = 0; k < NumRows; k++) begin
         if (DirectedRows[k].kind == ROW_CSR) begin
            if (!writing) begin
               settle();
               settings_used++;
            end
            writing = 1'b1;
            csr_write(DirectedRows[k].addr, DirectedRows[k].wdata);
         end else begin
            if (writing) begin
               csr_we <= 1'b0;
            end
            writing = 1'b0;
            send_poll(DirectedRows[k].rssi, DirectedRows[k].snr, DirectedRows[k].tx,
                      DirectedRows[k].typed, DirectedRows[k].want);
            directed_polls++;
         end
      end
      for (p = 0; p < RandomPhases; p++) begin
         run_phase(p);
      end
      settle();
      $display("Covered %0d polls (%0d directed) over %0d register settings, %0d responses",
               polls_sent, directed_polls, settings_used, readings_seen);
      $display("Squelch opened %0d times and closed %0d times", opens, closes);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
